// ===== hdl/sbti_pkg.sv =====
// ----------------------------------------------------------------------------
// sbti_pkg
// Shared constants, types and codes of the swept box / tile intersection pipe.
// ----------------------------------------------------------------------------
package sbti_pkg;

    localparam int TILE_INDEX_BITS = 10;
    localparam int TIME_FRAC_BITS  = 16;

    localparam int CFG_W   = 13;
    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int STEP_W  = 18;

    // slab time, signed, range [-2.0, +2.0]
    localparam int TIME_W = TIME_FRAC_BITS + 3;
    // contact time, unsigned, range [0, 1.0]
    localparam int CT_W   = TIME_FRAC_BITS + 1;

    localparam int T_ONE = 1 << TIME_FRAC_BITS;
    localparam int T_MAX = 2 << TIME_FRAC_BITS;

    // doubled centre, tile edges, edge distance, displacement
    localparam int O2_W   = COORD_W + 3;
    localparam int BASE_W = TILE_INDEX_BITS + CFG_W;
    localparam int EDGE_W = BASE_W + 19;
    localparam int E_W    = EDGE_W + 1;
    localparam int D_W    = COORD_W + STEP_W;
    localparam int UE_W   = E_W - 1;
    localparam int UD_W   = D_W - 1;

    // divider: dividend scaled by 2^(TIME_FRAC_BITS + 15) ahead of the division
    localparam int DIV_SH = TIME_FRAC_BITS + 15;
    localparam int QB     = TIME_FRAC_BITS + 2;
    localparam int SAT_SH = DIV_SH - QB;
    localparam int RW     = UE_W + DIV_SH;

    // contact point arithmetic
    localparam int DLO_W  = 25;
    localparam int PROD_W = CT_W + D_W + 1;
    localparam int SUM_W  = PROD_W - TIME_FRAC_BITS + 1;

    // pipeline depth
    localparam int FRONT_ST = 3;
    localparam int DIV_ST   = QB + 3;
    localparam int BACK_ST  = 4;
    localparam int NS       = FRONT_ST + DIV_ST + BACK_ST;

    typedef enum logic [0:0] {
        CFG_TILE_W = 1'b0,
        CFG_TILE_H = 1'b1
    } t_cfg_idx;

    localparam logic [1:0] NRM_NONE = 2'b00;
    localparam logic [1:0] NRM_POS  = 2'b01;
    localparam logic [1:0] NRM_NEG  = 2'b11;

    typedef struct packed {
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  box_off_x;
        logic signed [COORD_W-1:0]  box_off_y;
        logic [SIZE_W-1:0]          box_w;
        logic [SIZE_W-1:0]          box_h;
        logic signed [COORD_W-1:0]  vel_x;
        logic signed [COORD_W-1:0]  vel_y;
        logic [TILE_INDEX_BITS-1:0] tile_x;
        logic [TILE_INDEX_BITS-1:0] tile_y;
        logic [STEP_W-1:0]          step_time;
    } t_in_word;

    typedef struct packed {
        logic signed [O2_W-1:0] o2;
        logic signed [D_W-1:0]  d;
        logic                   dz;
        logic                   in_slab;
    } t_axis_side;

    typedef struct packed {
        t_axis_side x;
        t_axis_side y;
        logic       vzero;
    } t_side;

endpackage

// ===== hdl/sbti_in_if.sv =====
// ----------------------------------------------------------------------------
// sbti_in_if
// Input channel: one box / tile pair per word.
// ----------------------------------------------------------------------------
interface sbti_in_if;
    import sbti_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  box_off_x;
    logic signed [COORD_W-1:0]  box_off_y;
    logic [SIZE_W-1:0]          box_w;
    logic [SIZE_W-1:0]          box_h;
    logic signed [COORD_W-1:0]  vel_x;
    logic signed [COORD_W-1:0]  vel_y;
    logic [TILE_INDEX_BITS-1:0] tile_x;
    logic [TILE_INDEX_BITS-1:0] tile_y;
    logic [STEP_W-1:0]          step_time;

    modport source (
        output valid, pos_x, pos_y, box_off_x, box_off_y, box_w, box_h,
               vel_x, vel_y, tile_x, tile_y, step_time,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, box_off_x, box_off_y, box_w, box_h,
               vel_x, vel_y, tile_x, tile_y, step_time,
        output ready
    );
endinterface

// ===== hdl/sbti_out_if.sv =====
// ----------------------------------------------------------------------------
// sbti_out_if
// Result channel: hit flag, contact point, normal and contact time.
// ----------------------------------------------------------------------------
interface sbti_out_if;
    import sbti_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic signed [COORD_W-1:0] contact_x;
    logic signed [COORD_W-1:0] contact_y;
    logic signed [1:0]         normal_x;
    logic signed [1:0]         normal_y;
    logic [CT_W-1:0]           hit_time;

    modport source (
        output valid, hit, contact_x, contact_y, normal_x, normal_y, hit_time,
        input  ready
    );
    modport sink (
        input  valid, hit, contact_x, contact_y, normal_x, normal_y, hit_time,
        output ready
    );
endinterface

// ===== hdl/sbti_front.sv =====
// ----------------------------------------------------------------------------
// sbti_front
// Three stages: centre, displacement and tile base; grown tile edges;
// edge distances and zero-displacement inside test.
// ----------------------------------------------------------------------------
module sbti_front (
    input  logic                          i_clk,
    input  logic [sbti_pkg::FRONT_ST-1:0] i_en,
    input  logic [sbti_pkg::CFG_W-1:0]    i_tile_w,
    input  logic [sbti_pkg::CFG_W-1:0]    i_tile_h,
    input  sbti_pkg::t_in_word            i_word,
    output logic signed [sbti_pkg::E_W-1:0] o_e_lo_x,
    output logic signed [sbti_pkg::E_W-1:0] o_e_hi_x,
    output logic signed [sbti_pkg::E_W-1:0] o_e_lo_y,
    output logic signed [sbti_pkg::E_W-1:0] o_e_hi_y,
    output sbti_pkg::t_side               o_side
);
    import sbti_pkg::*;

    // stage 0
    logic signed [O2_W-1:0] r0_o2x, r0_o2y, n0_o2x, n0_o2y;
    logic [BASE_W-1:0]      r0_bx, r0_by, n0_bx, n0_by;
    logic [SIZE_W-1:0]      r0_bw, r0_bh;
    logic [CFG_W-1:0]       r0_tw, r0_th;
    logic signed [D_W-1:0]  r0_dx, r0_dy, n0_dx, n0_dy;
    logic                   r0_vz;

    // stage 1
    logic signed [EDGE_W-1:0] r1_lx, r1_hx, r1_ly, r1_hy;
    logic signed [EDGE_W-1:0] n1_lx, n1_hx, n1_ly, n1_hy;
    logic signed [O2_W-1:0]   r1_o2x, r1_o2y;
    logic signed [D_W-1:0]    r1_dx, r1_dy;
    logic                     r1_dzx, r1_dzy, r1_vz;

    // stage 2
    logic signed [E_W-1:0] w_o2x_e, w_o2y_e;
    logic signed [E_W-1:0] w_lx_e, w_hx_e, w_ly_e, w_hy_e;

    always_comb begin
        n0_o2x = $signed({{2{i_word.pos_x[COORD_W-1]}}, i_word.pos_x, 1'b0})
               + $signed({{2{i_word.box_off_x[COORD_W-1]}}, i_word.box_off_x, 1'b0})
               + $signed({{(O2_W-SIZE_W){1'b0}}, i_word.box_w});
        n0_o2y = $signed({{2{i_word.pos_y[COORD_W-1]}}, i_word.pos_y, 1'b0})
               + $signed({{2{i_word.box_off_y[COORD_W-1]}}, i_word.box_off_y, 1'b0})
               + $signed({{(O2_W-SIZE_W){1'b0}}, i_word.box_h});
        n0_bx  = i_word.tile_x * i_tile_w;
        n0_by  = i_word.tile_y * i_tile_h;
        n0_dx  = i_word.vel_x * $signed({1'b0, i_word.step_time});
        n0_dy  = i_word.vel_y * $signed({1'b0, i_word.step_time});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_o2x <= n0_o2x;
            r0_o2y <= n0_o2y;
            r0_bx  <= n0_bx;
            r0_by  <= n0_by;
            r0_bw  <= i_word.box_w;
            r0_bh  <= i_word.box_h;
            r0_tw  <= i_tile_w;
            r0_th  <= i_tile_h;
            r0_dx  <= n0_dx;
            r0_dy  <= n0_dy;
            r0_vz  <= (i_word.vel_x == '0) && (i_word.vel_y == '0);
        end
    end

    // edges at twice their value, 16 fraction bits
    always_comb begin
        n1_lx = $signed({2'b00, r0_bx, 17'b0})
              - $signed({{(EDGE_W-SIZE_W){1'b0}}, r0_bw});
        n1_hx = $signed({2'b00, r0_bx, 17'b0})
              + $signed({{(EDGE_W-CFG_W-17){1'b0}}, r0_tw, 17'b0})
              + $signed({{(EDGE_W-SIZE_W){1'b0}}, r0_bw});
        n1_ly = $signed({2'b00, r0_by, 17'b0})
              - $signed({{(EDGE_W-SIZE_W){1'b0}}, r0_bh});
        n1_hy = $signed({2'b00, r0_by, 17'b0})
              + $signed({{(EDGE_W-CFG_W-17){1'b0}}, r0_th, 17'b0})
              + $signed({{(EDGE_W-SIZE_W){1'b0}}, r0_bh});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_lx  <= n1_lx;
            r1_hx  <= n1_hx;
            r1_ly  <= n1_ly;
            r1_hy  <= n1_hy;
            r1_o2x <= r0_o2x;
            r1_o2y <= r0_o2y;
            r1_dx  <= r0_dx;
            r1_dy  <= r0_dy;
            r1_dzx <= (r0_dx == '0);
            r1_dzy <= (r0_dy == '0);
            r1_vz  <= r0_vz;
        end
    end

    always_comb begin
        w_o2x_e = $signed({{(E_W-O2_W){r1_o2x[O2_W-1]}}, r1_o2x});
        w_o2y_e = $signed({{(E_W-O2_W){r1_o2y[O2_W-1]}}, r1_o2y});
        w_lx_e  = $signed({r1_lx[EDGE_W-1], r1_lx});
        w_hx_e  = $signed({r1_hx[EDGE_W-1], r1_hx});
        w_ly_e  = $signed({r1_ly[EDGE_W-1], r1_ly});
        w_hy_e  = $signed({r1_hy[EDGE_W-1], r1_hy});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_e_lo_x         <= w_lx_e - w_o2x_e;
            o_e_hi_x         <= w_hx_e - w_o2x_e;
            o_e_lo_y         <= w_ly_e - w_o2y_e;
            o_e_hi_y         <= w_hy_e - w_o2y_e;
            o_side.x.o2      <= r1_o2x;
            o_side.x.d       <= r1_dx;
            o_side.x.dz      <= r1_dzx;
            o_side.x.in_slab <= (w_o2x_e > w_lx_e) && (w_o2x_e < w_hx_e);
            o_side.y.o2      <= r1_o2y;
            o_side.y.d       <= r1_dy;
            o_side.y.dz      <= r1_dzy;
            o_side.y.in_slab <= (w_o2y_e > w_ly_e) && (w_o2y_e < w_hy_e);
            o_side.vzero     <= r1_vz;
        end
    end

endmodule

// ===== hdl/sbti_div.sv =====
// ----------------------------------------------------------------------------
// sbti_div
// Pipelined signed divider for one slab time: floor(e * 2^DIV_SH / d)
// clamped to [-2.0, +2.0], one quotient bit per stage.
// ----------------------------------------------------------------------------
module sbti_div (
    input  logic                          i_clk,
    input  logic [sbti_pkg::DIV_ST-1:0]   i_en,
    input  logic signed [sbti_pkg::E_W-1:0] i_e,
    input  logic signed [sbti_pkg::D_W-1:0] i_d,
    output logic signed [sbti_pkg::TIME_W-1:0] o_q
);
    import sbti_pkg::*;

    logic [E_W-1:0]  w_ae;
    logic [D_W-1:0]  w_ad;
    logic [UE_W-1:0] r_ue;
    logic [UD_W-1:0] r_ud0;
    logic            r_neg0;

    logic [RW-1:0]   r_rem [QB+1];
    logic [UD_W-1:0] r_ud  [QB+1];
    logic [QB-1:0]   r_q   [QB+1];
    logic            r_neg [QB+1];
    logic            r_sat [QB+1];

    logic [RW-1:0]   w_dsh [QB];
    logic            w_ge  [QB];
    logic [RW-1:0]   n_rem [QB];
    logic [QB-1:0]   n_q   [QB];

    logic [TIME_W-1:0] w_mag;

    always_comb begin
        w_ae = i_e[E_W-1] ? -i_e : i_e;
        w_ad = i_d[D_W-1] ? -i_d : i_d;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_ue   <= w_ae[UE_W-1:0];
            r_ud0  <= w_ad[UD_W-1:0];
            r_neg0 <= (i_e != '0) && (i_e[E_W-1] != i_d[D_W-1]);
        end
    end

    always_comb begin
        for (int j = 0; j < QB; j++) begin
            w_dsh[j] = RW'(r_ud[j]) << (QB - 1 - j);
            w_ge[j]  = r_rem[j] >= w_dsh[j];
            n_rem[j] = w_ge[j] ? r_rem[j] - w_dsh[j] : r_rem[j];
            n_q[j]   = r_q[j] | (QB'(w_ge[j]) << (QB - 1 - j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_rem[0] <= {r_ue, {DIV_SH{1'b0}}};
            r_ud[0]  <= r_ud0;
            r_q[0]   <= '0;
            r_neg[0] <= r_neg0;
            // quotient would not fit below 2^QB
            r_sat[0] <= {r_ue, {SAT_SH{1'b0}}} >= r_ud0;
        end
        for (int j = 0; j < QB; j++) begin
            if (i_en[j+2]) begin
                r_rem[j+1] <= n_rem[j];
                r_ud[j+1]  <= r_ud[j];
                r_q[j+1]   <= n_q[j];
                r_neg[j+1] <= r_neg[j];
                r_sat[j+1] <= r_sat[j];
            end
        end
    end

    // floor of a negative quotient rounds the magnitude up
    always_comb begin
        if (r_sat[QB]) begin
            w_mag = TIME_W'(T_MAX);
        end else begin
            w_mag = {1'b0, r_q[QB]} + TIME_W'(r_neg[QB] && (r_rem[QB] != '0));
        end
        if (w_mag > TIME_W'(T_MAX)) begin
            w_mag = TIME_W'(T_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[QB+2]) begin
            o_q <= r_neg[QB] ? -$signed(w_mag) : $signed(w_mag);
        end
    end

endmodule

// ===== hdl/sbti_back.sv =====
// ----------------------------------------------------------------------------
// sbti_back
// Slab merge and hit decision, then contact point: partial products,
// product sum, centre add with saturation.
// ----------------------------------------------------------------------------
module sbti_back (
    input  logic                               i_clk,
    input  logic [sbti_pkg::BACK_ST-1:0]       i_en,
    input  logic signed [sbti_pkg::TIME_W-1:0] i_qlx,
    input  logic signed [sbti_pkg::TIME_W-1:0] i_qhx,
    input  logic signed [sbti_pkg::TIME_W-1:0] i_qly,
    input  logic signed [sbti_pkg::TIME_W-1:0] i_qhy,
    input  sbti_pkg::t_side                    i_side,
    output logic                               o_hit,
    output logic signed [sbti_pkg::COORD_W-1:0] o_cx,
    output logic signed [sbti_pkg::COORD_W-1:0] o_cy,
    output logic [1:0]                         o_nx,
    output logic [1:0]                         o_ny,
    output logic [sbti_pkg::CT_W-1:0]          o_ct
);
    import sbti_pkg::*;

    localparam logic signed [TIME_W-1:0] TMAX_S = TIME_W'(T_MAX);
    localparam logic signed [TIME_W-1:0] TONE_S = TIME_W'(T_ONE);
    localparam int PH_W = CT_W + 1 + D_W - DLO_W;
    localparam int PL_W = CT_W + DLO_W;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v
    );
        logic [SUM_W-COORD_W:0] top;
        top = v[SUM_W-1:COORD_W-1];
        if (!v[SUM_W-1] && (top != '0)) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end else if (v[SUM_W-1] && (top != '1)) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        return v[COORD_W-1:0];
    endfunction

    logic signed [TIME_W-1:0] w_nx, w_fx, w_ny, w_fy, w_tn, w_tf;
    logic                     w_hit;
    logic [1:0]               n_nx, n_ny;

    logic                   ra_hit;
    logic [CT_W-1:0]        ra_t;
    logic [1:0]             ra_nx, ra_ny;
    logic signed [O2_W-1:0] ra_o2x, ra_o2y;
    logic signed [D_W-1:0]  ra_dx, ra_dy;

    logic                     rb_hit;
    logic [CT_W-1:0]          rb_t;
    logic [1:0]               rb_nx, rb_ny;
    logic signed [O2_W-1:0]   rb_o2x, rb_o2y;
    logic signed [PH_W-1:0]   rb_phx, rb_phy, n_phx, n_phy;
    logic [PL_W-1:0]          rb_plx, rb_ply, n_plx, n_ply;

    logic                     rc_hit;
    logic [CT_W-1:0]          rc_t;
    logic [1:0]               rc_nx, rc_ny;
    logic signed [O2_W-1:0]   rc_o2x, rc_o2y;
    logic signed [PROD_W-1:0] rc_px, rc_py;

    logic signed [SUM_W-1:0] w_sx, w_sy, w_csx, w_csy;

    // slab merge
    always_comb begin
        if (i_side.x.dz) begin
            w_nx = -TMAX_S;
            w_fx = TMAX_S;
        end else begin
            w_nx = (i_qlx < i_qhx) ? i_qlx : i_qhx;
            w_fx = (i_qlx < i_qhx) ? i_qhx : i_qlx;
        end
        if (i_side.y.dz) begin
            w_ny = -TMAX_S;
            w_fy = TMAX_S;
        end else begin
            w_ny = (i_qly < i_qhy) ? i_qly : i_qhy;
            w_fy = (i_qly < i_qhy) ? i_qhy : i_qly;
        end
        w_tn  = (w_nx > w_ny) ? w_nx : w_ny;
        w_tf  = (w_fx < w_fy) ? w_fx : w_fy;
        w_hit = !i_side.vzero
              && (!i_side.x.dz || i_side.x.in_slab)
              && (!i_side.y.dz || i_side.y.in_slab)
              && !(w_nx > w_fy) && !(w_ny > w_fx)
              && !w_tf[TIME_W-1] && !w_tn[TIME_W-1] && !(w_tn > TONE_S);
        n_nx = NRM_NONE;
        n_ny = NRM_NONE;
        if (w_hit && (w_nx > w_ny)) begin
            n_nx = i_side.x.d[D_W-1] ? NRM_POS : NRM_NEG;
        end else if (w_hit && (w_ny > w_nx)) begin
            n_ny = i_side.y.d[D_W-1] ? NRM_POS : NRM_NEG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            ra_hit <= w_hit;
            ra_t   <= w_hit ? w_tn[CT_W-1:0] : '0;
            ra_nx  <= n_nx;
            ra_ny  <= n_ny;
            ra_o2x <= i_side.x.o2;
            ra_o2y <= i_side.y.o2;
            ra_dx  <= i_side.x.d;
            ra_dy  <= i_side.y.d;
        end
    end

    // t * d split into a signed upper and an unsigned lower partial product
    always_comb begin
        n_phx = $signed({1'b0, ra_t}) * $signed(ra_dx[D_W-1:DLO_W]);
        n_phy = $signed({1'b0, ra_t}) * $signed(ra_dy[D_W-1:DLO_W]);
        n_plx = ra_t * ra_dx[DLO_W-1:0];
        n_ply = ra_t * ra_dy[DLO_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            rb_hit <= ra_hit;
            rb_t   <= ra_t;
            rb_nx  <= ra_nx;
            rb_ny  <= ra_ny;
            rb_o2x <= ra_o2x;
            rb_o2y <= ra_o2y;
            rb_phx <= n_phx;
            rb_phy <= n_phy;
            rb_plx <= n_plx;
            rb_ply <= n_ply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            rc_hit <= rb_hit;
            rc_t   <= rb_t;
            rc_nx  <= rb_nx;
            rc_ny  <= rb_ny;
            rc_o2x <= rb_o2x;
            rc_o2y <= rb_o2y;
            rc_px  <= $signed({rb_phx, {DLO_W{1'b0}}})
                    + $signed({{(PROD_W-PL_W){1'b0}}, rb_plx});
            rc_py  <= $signed({rb_phy, {DLO_W{1'b0}}})
                    + $signed({{(PROD_W-PL_W){1'b0}}, rb_ply});
        end
    end

    // centre at 32 fraction bits plus floor(t * d), then down to 16
    always_comb begin
        w_sx  = $signed({{(SUM_W-O2_W-15){rc_o2x[O2_W-1]}}, rc_o2x, 15'b0})
              + $signed({rc_px[PROD_W-1], rc_px[PROD_W-1:TIME_FRAC_BITS]});
        w_sy  = $signed({{(SUM_W-O2_W-15){rc_o2y[O2_W-1]}}, rc_o2y, 15'b0})
              + $signed({rc_py[PROD_W-1], rc_py[PROD_W-1:TIME_FRAC_BITS]});
        w_csx = w_sx >>> 16;
        w_csy = w_sy >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            o_hit <= rc_hit;
            o_cx  <= rc_hit ? sat_coord(w_csx) : '0;
            o_cy  <= rc_hit ? sat_coord(w_csy) : '0;
            o_nx  <= rc_nx;
            o_ny  <= rc_ny;
            o_ct  <= rc_t;
        end
    end

endmodule

// ===== hdl/swept_box_tile_intersection.sv =====
// ----------------------------------------------------------------------------
// swept_box_tile_intersection
// Swept box against one grid tile: slab test with near/far times, contact
// point, axis normal and contact time, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          word
//  i_in      in    valid / ready      box position, offset, size, velocity,
//                                     tile column and row, time step
//  o_out     out   valid / ready      hit, contact x/y, normal x/y, time
//  i_cfg_*   in    write enable only  tile width (0), tile height (1)
//
//  one word per cycle while the pipe is not stalled; 3 setup stages, 21 divider
//  stages (abs, init, one per quotient bit, output), 4 merge and contact stages
//  every stage carries a valid bit; a stage loads when it or a later stage
//  holds a bubble or the output word is taken, so bubbles collapse on stall
//  reset clears the valid bits and sets both tile sizes to 16
// ----------------------------------------------------------------------------
module swept_box_tile_intersection (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  sbti_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [sbti_pkg::CFG_W-1:0] i_cfg_data,
    sbti_in_if.sink                    i_in,
    sbti_out_if.source                 o_out
);
    import sbti_pkg::*;

    localparam int DIV0 = FRONT_ST;
    localparam int BK0  = FRONT_ST + DIV_ST;

    logic [CFG_W-1:0] r_tile_w, r_tile_h;
    logic [NS-1:0]    r_v;
    logic [NS-1:0]    w_en;
    t_in_word         w_word;

    logic signed [E_W-1:0]    w_elx, w_ehx, w_ely, w_ehy;
    t_side                    w_side;
    t_side                    r_side [DIV_ST];
    logic signed [TIME_W-1:0] w_qlx, w_qhx, w_qly, w_qhy;
    logic [1:0]               w_nx, w_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w <= CFG_W'(16);
            r_tile_h <= CFG_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TILE_W: r_tile_w <= i_cfg_data;
                CFG_TILE_H: r_tile_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage may load when any stage from it to the output is empty or the output is ready
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_en[k] = o_out.ready || !(&(r_v | ((NS'(1) << k) - NS'(1))));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign i_in.ready = w_en[0];

    always_comb begin
        w_word.pos_x     = i_in.pos_x;
        w_word.pos_y     = i_in.pos_y;
        w_word.box_off_x = i_in.box_off_x;
        w_word.box_off_y = i_in.box_off_y;
        w_word.box_w     = i_in.box_w;
        w_word.box_h     = i_in.box_h;
        w_word.vel_x     = i_in.vel_x;
        w_word.vel_y     = i_in.vel_y;
        w_word.tile_x    = i_in.tile_x;
        w_word.tile_y    = i_in.tile_y;
        w_word.step_time = i_in.step_time;
    end

    sbti_front u_front (
        .i_clk    (i_clk),
        .i_en     (w_en[FRONT_ST-1:0]),
        .i_tile_w (r_tile_w),
        .i_tile_h (r_tile_h),
        .i_word   (w_word),
        .o_e_lo_x (w_elx),
        .o_e_hi_x (w_ehx),
        .o_e_lo_y (w_ely),
        .o_e_hi_y (w_ehy),
        .o_side   (w_side)
    );

    sbti_div u_div_lx (
        .i_clk (i_clk), .i_en (w_en[BK0-1:DIV0]),
        .i_e (w_elx), .i_d (w_side.x.d), .o_q (w_qlx)
    );
    sbti_div u_div_hx (
        .i_clk (i_clk), .i_en (w_en[BK0-1:DIV0]),
        .i_e (w_ehx), .i_d (w_side.x.d), .o_q (w_qhx)
    );
    sbti_div u_div_ly (
        .i_clk (i_clk), .i_en (w_en[BK0-1:DIV0]),
        .i_e (w_ely), .i_d (w_side.y.d), .o_q (w_qly)
    );
    sbti_div u_div_hy (
        .i_clk (i_clk), .i_en (w_en[BK0-1:DIV0]),
        .i_e (w_ehy), .i_d (w_side.y.d), .o_q (w_qhy)
    );

    // side data delayed alongside the dividers
    always_ff @(posedge i_clk) begin
        if (w_en[DIV0]) begin
            r_side[0] <= w_side;
        end
        for (int k = 1; k < DIV_ST; k++) begin
            if (w_en[DIV0+k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    sbti_back u_back (
        .i_clk  (i_clk),
        .i_en   (w_en[NS-1:BK0]),
        .i_qlx  (w_qlx),
        .i_qhx  (w_qhx),
        .i_qly  (w_qly),
        .i_qhy  (w_qhy),
        .i_side (r_side[DIV_ST-1]),
        .o_hit  (o_out.hit),
        .o_cx   (o_out.contact_x),
        .o_cy   (o_out.contact_y),
        .o_nx   (w_nx),
        .o_ny   (w_ny),
        .o_ct   (o_out.hit_time)
    );

    assign o_out.normal_x = $signed(w_nx);
    assign o_out.normal_y = $signed(w_ny);
    assign o_out.valid    = r_v[NS-1];

    a_nohit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.hit |->
            o_out.contact_x == '0 && o_out.contact_y == '0 &&
            w_nx == NRM_NONE && w_ny == NRM_NONE && o_out.hit_time == '0)
        else $error("miss word carries nonzero contact data");

    a_ct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.hit |-> o_out.hit_time <= CT_W'(T_ONE))
        else $error("contact time beyond one step");

    a_one_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> w_nx == NRM_NONE || w_ny == NRM_NONE)
        else $error("both normal components set");

    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NS-1] |-> i_in.ready)
        else $error("input stalled with an empty output stage");

endmodule

// ===== verif/tb_swept_box_tile_intersection.sv =====
// ----------------------------------------------------------------------------
// tb_swept_box_tile_intersection
// Self-checking bench for the swept box / tile intersection pipe. Words are
// sent on the input channel with random gaps. Each accepted word is run
// through a bit-exact slab test predictor, and every result word is compared
// with it field by field. The tile size registers are swept between phases.
// ----------------------------------------------------------------------------
module tb_swept_box_tile_intersection;
    timeunit 1ns;
    timeprecision 1ps;
    import sbti_pkg::*;

    typedef struct {
        logic                      hit;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [1:0]         nx;
        logic signed [1:0]         ny;
        logic [CT_W-1:0]           ct;
    } t_contact;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    t_cfg_idx            cfg_idx;
    logic [CFG_W-1:0]    cfg_data;

    sbti_in_if  in_ch ();
    sbti_out_if out_ch ();

    swept_box_tile_intersection u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    longint   tile_w_q;
    longint   tile_h_q;
    t_contact contact_q[$];
    bit       send_gaps;
    bit       recv_stalls;
    int       n_errors;
    int       n_words;
    int       n_results;
    int       n_hits;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL swept_box_tile_intersection");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    // floor(e * 2^(15+F) / d), clamped to [-2.0, +2.0]
    function automatic longint slab_time(longint e, longint d);
        longint unsigned ue, ud, q, r, mag;
        bit neg, sat;
        ue  = (e < 0) ? -e : e;
        ud  = (d < 0) ? -d : d;
        neg = (e != 0) && ((e < 0) != (d < 0));
        q   = ue / ud;
        r   = ue % ud;
        sat = q > T_MAX;
        for (int i = 0; i < 15 + TIME_FRAC_BITS && !sat; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r = r - ud;
                q = q | 1;
            end
            if (q > T_MAX) sat = 1'b1;
        end
        mag = sat ? T_MAX : q;
        if (neg && !sat && r != 0) mag++;
        if (mag > T_MAX) mag = T_MAX;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic bit slab_span(longint lo, longint hi, longint o, longint d,
                                     output longint t_near, output longint t_far);
        longint a, b;
        if (d == 0) begin
            t_near = -T_MAX;
            t_far  = T_MAX;
            return (o > lo) && (o < hi);
        end
        a = slab_time(lo - o, d);
        b = slab_time(hi - o, d);
        t_near = (a < b) ? a : b;
        t_far  = (a < b) ? b : a;
        return 1'b1;
    endfunction

    function automatic logic [COORD_W-1:0] contact_coord(longint o2, longint d, longint t);
        longint dh, dl, a, c;
        dh = d >>> TIME_FRAC_BITS;
        dl = d - dh * (longint'(1) << TIME_FRAC_BITS);
        a  = t * dh + ((t * dl) >>> TIME_FRAC_BITS);
        c  = (o2 * 32768 + a) >>> 16;
        if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
        if (c < -64'sh8000_0000) c = -64'sh8000_0000;
        return c[COORD_W-1:0];
    endfunction

    function automatic t_contact sweep_tile(t_in_word w);
        t_contact res;
        longint px, py, vx, vy, ox2, oy2, lx, hx, ly, hy, dx, dy;
        longint bw, bh, tx, ty, st, nx, fx, ny, fy, tn, tf;
        res = '{hit: 1'b0, cx: '0, cy: '0, nx: NRM_NONE, ny: NRM_NONE, ct: '0};
        px = $signed(w.pos_x);
        py = $signed(w.pos_y);
        vx = $signed(w.vel_x);
        vy = $signed(w.vel_y);
        bw = w.box_w;
        bh = w.box_h;
        tx = w.tile_x;
        ty = w.tile_y;
        st = w.step_time;
        if (vx == 0 && vy == 0) return res;
        ox2 = 2 * (px + longint'($signed(w.box_off_x))) + bw;
        oy2 = 2 * (py + longint'($signed(w.box_off_y))) + bh;
        lx  = 2 * (tx * tile_w_q * 65536) - bw;
        hx  = 2 * (tx * tile_w_q * 65536) + 2 * (tile_w_q * 65536) + bw;
        ly  = 2 * (ty * tile_h_q * 65536) - bh;
        hy  = 2 * (ty * tile_h_q * 65536) + 2 * (tile_h_q * 65536) + bh;
        dx  = vx * st;
        dy  = vy * st;
        if (!slab_span(lx, hx, ox2, dx, nx, fx)) return res;
        if (!slab_span(ly, hy, oy2, dy, ny, fy)) return res;
        if (nx > fy || ny > fx) return res;
        tn = (nx > ny) ? nx : ny;
        tf = (fx < fy) ? fx : fy;
        if (tf < 0 || tn < 0 || tn > T_ONE) return res;
        res.hit = 1'b1;
        res.cx  = contact_coord(ox2, dx, tn);
        res.cy  = contact_coord(oy2, dy, tn);
        if (nx > ny) res.nx = (dx < 0) ? NRM_POS : NRM_NEG;
        else if (ny > nx) res.ny = (dy < 0) ? NRM_POS : NRM_NEG;
        res.ct = tn[CT_W-1:0];
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    always @(posedge i_clk) begin
        if (recv_stalls) out_ch.ready <= ($urandom_range(99) >= 28);
        else out_ch.ready <= 1'b1;
    end

    task automatic send_word(t_in_word w);
        while (send_gaps && $urandom_range(99) < 28) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.pos_x     <= w.pos_x;
        in_ch.pos_y     <= w.pos_y;
        in_ch.box_off_x <= w.box_off_x;
        in_ch.box_off_y <= w.box_off_y;
        in_ch.box_w     <= w.box_w;
        in_ch.box_h     <= w.box_h;
        in_ch.vel_x     <= w.vel_x;
        in_ch.vel_y     <= w.vel_y;
        in_ch.tile_x    <= w.tile_x;
        in_ch.tile_y    <= w.tile_y;
        in_ch.step_time <= w.step_time;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        contact_q.insert(contact_q.size(), sweep_tile(w));
        n_words++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (contact_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_tile_size(t_cfg_idx idx, logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TILE_W) tile_w_q = val;
        else tile_h_q = val;
    endtask

    // ---------------------------------------------------------------- checker

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d want %0d (result %0d)", field, got, want, n_results);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        t_contact want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (contact_q.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = contact_q.pop_front();
                if (out_ch.hit !== want.hit) report_mismatch("hit", out_ch.hit, want.hit);
                if (out_ch.contact_x !== want.cx)
                    report_mismatch("contact_x", out_ch.contact_x, want.cx);
                if (out_ch.contact_y !== want.cy)
                    report_mismatch("contact_y", out_ch.contact_y, want.cy);
                if (out_ch.normal_x !== want.nx)
                    report_mismatch("normal_x", out_ch.normal_x, want.nx);
                if (out_ch.normal_y !== want.ny)
                    report_mismatch("normal_y", out_ch.normal_y, want.ny);
                if (out_ch.hit_time !== want.ct)
                    report_mismatch("hit_time", out_ch.hit_time, want.ct);
                if (want.hit) n_hits++;
            end
            n_results++;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [31:0] q16(longint v);
        return 32'(v <<< 16);
    endfunction

    function automatic t_in_word make_word(longint px, longint py, longint vx, longint vy,
                                           int tx, int ty, longint bw, longint bh,
                                           logic [STEP_W-1:0] st);
        t_in_word w;
        w.pos_x = q16(px);      w.pos_y = q16(py);
        w.box_off_x = '0;       w.box_off_y = '0;
        w.box_w = 31'(bw <<< 16);
        w.box_h = 31'(bh <<< 16);
        w.vel_x = q16(vx);      w.vel_y = q16(vy);
        w.tile_x = tx[TILE_INDEX_BITS-1:0];
        w.tile_y = ty[TILE_INDEX_BITS-1:0];
        w.step_time = st;
        return w;
    endfunction

    function automatic t_in_word noise_word();
        t_in_word w;
        logic [319:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom};
        w = bits[$bits(t_in_word)-1:0];
        if ($urandom_range(3) == 0) w.vel_x = '0;
        if ($urandom_range(3) == 0) w.vel_y = '0;
        return w;
    endfunction

    // a box placed around a tile and mostly aimed at it
    function automatic t_in_word aimed_word();
        t_in_word w;
        longint tw, th, lim_x, lim_y, tx, ty, px, py, cx, cy, k;
        tw = (tile_w_q == 0) ? 1 : tile_w_q;
        th = (tile_h_q == 0) ? 1 : tile_h_q;
        lim_x = 20000 / tw;
        lim_y = 20000 / th;
        if (lim_x > 1023) lim_x = 1023;
        if (lim_y > 1023) lim_y = 1023;
        tx = $urandom_range(int'(lim_x));
        ty = $urandom_range(int'(lim_y));
        px = ((tx * tw) <<< 16) + longint'($signed($urandom)) % ((4 * tw + 4) <<< 16);
        py = ((ty * th) <<< 16) + longint'($signed($urandom)) % ((4 * th + 4) <<< 16);
        cx = ((tx * tw) <<< 16) + (tw <<< 15);
        cy = ((ty * th) <<< 16) + (th <<< 15);
        k  = $urandom_range(512, 16);
        w.pos_x = 32'(px);
        w.pos_y = 32'(py);
        w.box_off_x = 32'(-longint'($urandom_range(2 << 16)));
        w.box_off_y = 32'(-longint'($urandom_range(2 << 16)));
        w.box_w = 31'($urandom_range(4 << 16));
        w.box_h = 31'($urandom_range(4 << 16));
        w.vel_x = 32'(((cx - px) * k) >>> 8);
        w.vel_y = 32'(((cy - py) * k) >>> 8);
        if ($urandom_range(9) == 0) w.vel_x = '0;
        else if ($urandom_range(9) == 0) w.vel_y = '0;
        w.tile_x = tx[TILE_INDEX_BITS-1:0];
        w.tile_y = ty[TILE_INDEX_BITS-1:0];
        w.step_time = ($urandom_range(1) == 0) ? STEP_W'(T_ONE) : STEP_W'($urandom);
        return w;
    endfunction

    task automatic test_directed();
        t_in_word w;
        // tile (2,3) spans x 32..48, y 48..64 at the reset size of 16
        send_word(make_word(20, 55, 16, 0, 2, 3, 2, 2, STEP_W'(T_ONE)));   // from the left
        send_word(make_word(60, 55, -16, 0, 2, 3, 2, 2, STEP_W'(T_ONE)));  // from the right
        send_word(make_word(40, 30, 0, 24, 2, 3, 2, 2, STEP_W'(T_ONE)));   // from above
        send_word(make_word(40, 80, 0, -24, 2, 3, 2, 2, STEP_W'(T_ONE)));  // from below
        send_word(make_word(20, 36, 16, 16, 2, 3, 2, 2, STEP_W'(T_ONE)));  // corner tie
        send_word(make_word(40, 55, 0, 0, 2, 3, 2, 2, STEP_W'(T_ONE)));    // no velocity
        send_word(make_word(40, 55, 3, 0, 2, 3, 2, 2, STEP_W'(T_ONE)));    // starts inside
        send_word(make_word(31, 30, 0, 40, 2, 3, 2, 2, STEP_W'(T_ONE)));   // on x edge, dx 0
        send_word(make_word(20, 30, 0, 40, 2, 3, 2, 2, STEP_W'(T_ONE)));   // outside x slab
        send_word(make_word(20, 55, 16, 0, 2, 3, 2, 2, '0));               // zero step
        send_word(make_word(20, 55, 4, 0, 2, 3, 2, 2, STEP_W'(T_ONE)));    // falls short
        send_word(make_word(20, 55, 4, 0, 2, 3, 2, 2, '1));                // long step
        send_word(make_word(50, 55, 16, 0, 2, 3, 2, 2, STEP_W'(T_ONE)));   // moving away
        send_word(make_word(16360, 16360, 10, 10, 1023, 1023, 0, 0, STEP_W'(T_ONE)));
        w = make_word(0, 0, 0, 0, 0, 0, 0, 0, '1);
        w.pos_x = 32'h7FFF_FFFF;  w.pos_y = 32'h8000_0000;
        w.box_off_x = 32'h7FFF_FFFF;  w.box_off_y = 32'h8000_0000;
        w.box_w = '1;  w.box_h = '1;
        w.vel_x = 32'h8000_0000;  w.vel_y = 32'h7FFF_FFFF;
        w.tile_x = '1;  w.tile_y = '1;
        send_word(w);
        w.box_w = '1;  w.box_h = '1;
        w.pos_x = '0;  w.pos_y = '0;  w.box_off_x = '0;  w.box_off_y = '0;
        w.vel_x = 32'h7FFF_FFFF;  w.vel_y = 32'h8000_0000;  w.tile_x = '0;  w.tile_y = '0;
        send_word(w);  // huge box, saturating contact point
        w.vel_x = 32'h0000_0001;  w.vel_y = 32'hFFFF_FFFF;  w.step_time = 18'd1;
        send_word(w);  // tiniest displacement
        wait_drained();
    endtask

    task automatic test_drain_pause();
        repeat (10) send_word(aimed_word());
        wait_drained();
        repeat (10) send_word(aimed_word());
        wait_drained();
    endtask

    task automatic test_random_phase(logic [CFG_W-1:0] tw, logic [CFG_W-1:0] th, int count);
        write_tile_size(CFG_TILE_W, tw);
        write_tile_size(CFG_TILE_H, th);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 70) send_word(aimed_word());
            else send_word(noise_word());
        end
        wait_drained();
    endtask

    task automatic test_no_idle();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        test_random_phase(13'd16, 13'd16, 60);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_TILE_W;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.pos_x     = '0;
        in_ch.pos_y     = '0;
        in_ch.box_off_x = '0;
        in_ch.box_off_y = '0;
        in_ch.box_w     = '0;
        in_ch.box_h     = '0;
        in_ch.vel_x     = '0;
        in_ch.vel_y     = '0;
        in_ch.tile_x    = '0;
        in_ch.tile_y    = '0;
        in_ch.step_time = '0;
        out_ch.ready    = 1'b0;
        tile_w_q        = 16;
        tile_h_q        = 16;
        send_gaps       = 1'b1;
        recv_stalls     = 1'b1;
        n_errors        = 0;
        n_words         = 0;
        n_results       = 0;
        n_hits          = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain_pause();
        test_random_phase(13'd1, 13'd4096, 60);
        test_random_phase(13'd4096, 13'd1, 60);
        test_no_idle();
        test_random_phase(13'd0, 13'd8191, 50);
        test_random_phase(13'd8191, 13'd0, 50);
        test_random_phase(13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)), 70);
        test_random_phase(13'd16, 13'd16, 20);

        $display("covered %0d words, %0d results, %0d hits", n_words, n_results, n_hits);
        $display("tile sizes swept 0..8191, extremes, ties, zero motion and saturation");
        if (n_errors == 0) begin
            $display("PASS swept_box_tile_intersection");
        end else begin
            $display("FAIL swept_box_tile_intersection");
        end
        $finish;
    end

endmodule

// ===== swept_box_tile_intersection.f =====
hdl/sbti_pkg.sv
hdl/sbti_in_if.sv
hdl/sbti_out_if.sv
hdl/sbti_front.sv
hdl/sbti_div.sv
hdl/sbti_back.sv
hdl/swept_box_tile_intersection.sv
verif/tb_swept_box_tile_intersection.sv
